// ===== hw/rtl/i2c_master_bit_sequencer_defines.svh =====
// Assertion macros shared by the checker of the I2C master bit sequencer.
// Depends on nothing; the including scope provides clk and rst.
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define I2CM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define I2CM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/i2cm_pkg.sv =====
// Types and constants of the I2C master bit sequencer.
// Used by the input stage, the sequencer core, the top level and the checker.
package i2cm_pkg;

  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 16;
  localparam int CFG_W     = 16;
  localparam int BC_W      = 4;

  localparam logic [CFG_W-1:0] DELAY_RESET = 16'd50;
  localparam logic [BC_W-1:0]  BYTE_BITS   = 4'd8;

  // Command codes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STOP  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // One tick offered to the sequencer
  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] mode;
    logic [6:0] address;
    logic       read_req;
    logic [7:0] data_byte;
    logic       ack_to_send;
    logic       sda_level;
  } cmd_t;

  // Pin drives and status after one tick
  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic       ack_bit;
    logic [7:0] read_data;
  } res_t;

endpackage

// ===== hw/rtl/i2cm_in_reg.sv =====
// Input register stage of the I2C master bit sequencer.
// Depends on i2cm_pkg for the tick payload type.
module i2cm_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  i2cm_pkg::cmd_t in_cmd,
  output logic          held_valid,
  output i2cm_pkg::cmd_t held_cmd,
  input  logic          take
);
  import i2cm_pkg::*;

  // Accept a beat when the slot is empty or is drained this cycle
  assign in_ready = !held_valid || take;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_cmd <= in_cmd;
    end
  end

endmodule

// ===== hw/rtl/i2cm_core.sv =====
// Phase sequencer of the I2C master: state registers and per-tick update.
// Depends on i2cm_pkg for the command and result types and codes.
module i2cm_core #(
  parameter int DELAY_COUNTER_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  i2cm_pkg::cmd_t               cmd,
  input  logic [i2cm_pkg::CFG_W-1:0]   bit_delay_ticks,
  output i2cm_pkg::res_t               res
);
  import i2cm_pkg::*;

  localparam int DW = DELAY_COUNTER_BITS;

  // Phase codes
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_S0    = 4'd1;
  localparam logic [3:0] PH_S1    = 4'd2;
  localparam logic [3:0] PH_S2    = 4'd3;
  localparam logic [3:0] PH_TXA   = 4'd4;
  localparam logic [3:0] PH_TXB   = 4'd5;
  localparam logic [3:0] PH_TXC   = 4'd6;
  localparam logic [3:0] PH_RXA   = 4'd7;
  localparam logic [3:0] PH_RXB   = 4'd8;
  localparam logic [3:0] PH_EXTRA = 4'd9;
  localparam logic [3:0] PH_P0    = 4'd10;
  localparam logic [3:0] PH_P1    = 4'd11;
  localparam logic [3:0] PH_P2    = 4'd12;

  logic [3:0]      phase, phase_next;
  logic [DW-1:0]   delay_count, delay_count_next;
  logic [BC_W-1:0] bit_count, bit_count_next;
  logic [7:0]      shift_reg, shift_reg_next;
  logic            scl_low, scl_low_next;
  logic            sda_low, sda_low_next;
  logic            ack_reg, ack_reg_next;
  logic [1:0]      cur_mode, cur_mode_next;
  logic            ack_choice, ack_choice_next;
  logic [7:0]      read_hold, read_hold_next;

  logic [CFG_W-1:0] dec;
  logic [DW-1:0]    reload;
  logic             go;
  logic             done;
  logic [3:0]       tgt;

  // Phase length minus one; zero acts as one
  assign dec = (bit_delay_ticks == '0) ? '0 : bit_delay_ticks - 1'b1;

  // Saturate the reload value to the counter width
  generate
    if (DW >= CFG_W) begin : g_wide
      assign reload = DW'(dec);
    end else begin : g_narrow
      assign reload = ((dec >> DW) != '0) ? {DW{1'b1}} : DW'(dec);
    end
  endgenerate

  // Work out the state after one tick
  always_comb begin
    phase_next       = phase;
    delay_count_next = delay_count;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    scl_low_next     = scl_low;
    sda_low_next     = sda_low;
    ack_reg_next     = ack_reg;
    cur_mode_next    = cur_mode;
    ack_choice_next  = ack_choice;
    read_hold_next   = read_hold;
    go               = 1'b0;
    done             = 1'b0;
    tgt              = phase;

    if (phase == PH_IDLE) begin
      if (cmd.cmd_valid) begin
        cur_mode_next  = cmd.mode;
        bit_count_next = '0;
        go             = 1'b1;
        case (cmd.mode)
          MODE_START: begin
            shift_reg_next = {cmd.address, cmd.read_req};
            tgt            = PH_S0;
          end
          MODE_STOP: begin
            tgt = PH_P0;
          end
          MODE_WRITE: begin
            shift_reg_next = cmd.data_byte;
            tgt            = PH_TXA;
          end
          default: begin
            ack_choice_next = cmd.ack_to_send;
            shift_reg_next  = '0;
            tgt             = PH_RXA;
          end
        endcase
      end
    end else if (delay_count != '0) begin
      delay_count_next = delay_count - 1'b1;
    end else begin
      go = 1'b1;
      case (phase)
        PH_S0:  tgt = PH_S1;
        PH_S1:  tgt = PH_S2;
        PH_S2: begin
          bit_count_next = '0;
          tgt            = PH_TXA;
        end
        PH_TXA: tgt = PH_TXB;
        PH_TXB: tgt = PH_TXC;
        PH_TXC: begin
          if (cur_mode == MODE_READ) begin
            tgt = PH_EXTRA;
          end else begin
            shift_reg_next = {shift_reg[6:0], 1'b0};
            bit_count_next = bit_count + 1'b1;
            tgt = (bit_count_next >= BYTE_BITS) ? PH_RXA : PH_TXA;
          end
        end
        PH_RXA: begin
          if (cur_mode == MODE_READ) begin
            shift_reg_next = {shift_reg[6:0], cmd.sda_level};
            bit_count_next = bit_count + 1'b1;
          end else begin
            ack_reg_next = cmd.sda_level;
          end
          tgt = PH_RXB;
        end
        PH_RXB: begin
          if (cur_mode != MODE_READ) begin
            go   = 1'b0;
            done = 1'b1;
          end else if (bit_count >= BYTE_BITS) begin
            read_hold_next = shift_reg;
            tgt            = PH_TXA;
          end else begin
            tgt = PH_RXA;
          end
        end
        PH_P0:  tgt = PH_P1;
        PH_P1:  tgt = PH_P2;
        default: begin
          go   = 1'b0;
          done = 1'b1;
        end
      endcase
    end

    // Finish the command
    if (done) begin
      phase_next       = PH_IDLE;
      delay_count_next = '0;
    end

    // Enter the new phase and set its pin levels
    if (go) begin
      phase_next       = tgt;
      delay_count_next = reload;
      case (tgt)
        PH_S0: begin
          scl_low_next = 1'b0;
          sda_low_next = 1'b0;
        end
        PH_S1:  sda_low_next = 1'b1;
        PH_S2:  scl_low_next = 1'b1;
        PH_TXA: begin
          if (cur_mode_next == MODE_READ) begin
            sda_low_next = ack_choice_next;
          end else begin
            sda_low_next = ~shift_reg_next[7];
          end
          scl_low_next = 1'b0;
        end
        PH_TXB: scl_low_next = 1'b1;
        PH_TXC: sda_low_next = 1'b1;
        PH_RXA: begin
          sda_low_next = 1'b0;
          scl_low_next = 1'b0;
        end
        PH_RXB: scl_low_next = 1'b1;
        PH_P0:  sda_low_next = 1'b1;
        PH_P1:  scl_low_next = 1'b0;
        PH_P2:  sda_low_next = 1'b0;
        default: begin
        end
      endcase
    end
  end

  // Advance the state on each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      delay_count <= '0;
      bit_count   <= '0;
      shift_reg   <= '0;
      scl_low     <= 1'b0;
      sda_low     <= 1'b0;
      ack_reg     <= 1'b0;
      cur_mode    <= MODE_START;
      ack_choice  <= 1'b0;
      read_hold   <= '0;
    end else if (step) begin
      phase       <= phase_next;
      delay_count <= delay_count_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      scl_low     <= scl_low_next;
      sda_low     <= sda_low_next;
      ack_reg     <= ack_reg_next;
      cur_mode    <= cur_mode_next;
      ack_choice  <= ack_choice_next;
      read_hold   <= read_hold_next;
    end
  end

  // Present the post-tick view
  always_comb begin
    res.scl_drive_low = scl_low_next;
    res.sda_drive_low = sda_low_next;
    res.busy_res      = (phase_next != PH_IDLE);
    res.done_res      = done;
    res.ack_bit       = ack_reg_next;
    res.read_data     = read_hold_next;
  end

endmodule

// ===== hw/rtl/i2c_master_bit_sequencer.sv =====
// Top level of the I2C master bit sequencer: input stage, core, result register.
// Depends on i2cm_pkg, i2cm_in_reg and i2cm_core.
//
//  channel  | direction | beat content
//  s_axis   | in        | one tick: command fields and sampled SDA level
//  m_axis   | out       | one result per tick: pin drives, busy, done, ack, read byte
//  cfg      | in        | bit_delay_ticks write, no read-back
//
// One tick is taken every clock cycle unless m_axis stalls; a tick is held in the input
// register, and its result in the result register. The limit is the single state update
// per cycle in the core: a tick depends on the state left by the one before.
// rst (synchronous) idles the sequencer, releases both lines, sets the delay to 50.
// A stall on m_axis holds the result register and fills the input stage, then
// drops s_axis_tready; nothing is lost or repeated.
module i2c_master_bit_sequencer #(
  parameter int DELAY_COUNTER_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // tuser: cmd_valid[0], mode[2:1]
  input  logic [i2cm_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  // tdata: address[6:0], read_req[7], data_byte[15:8], ack_to_send[16],
  //        sda_level[17], zero[23:18]
  input  logic [i2cm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: scl_drive_low[0], sda_drive_low[1], busy_res[2], done_res[3],
  //        ack_bit[4], read_data[12:5], zero[15:13]
  output logic [i2cm_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_wr_en,
  input  logic [i2cm_pkg::CFG_W-1:0]       cfg_wr_data
);
  import i2cm_pkg::*;

  cmd_t             in_cmd;
  cmd_t             held_cmd;
  logic             held_valid;
  logic             step;
  logic             out_free;
  res_t             res;
  logic [CFG_W-1:0] bit_delay_ticks;

  // Unpack the input beat
  always_comb begin
    in_cmd.cmd_valid   = s_axis_tuser[0];
    in_cmd.mode        = s_axis_tuser[2:1];
    in_cmd.address     = s_axis_tdata[6:0];
    in_cmd.read_req    = s_axis_tdata[7];
    in_cmd.data_byte   = s_axis_tdata[15:8];
    in_cmd.ack_to_send = s_axis_tdata[16];
    in_cmd.sda_level   = s_axis_tdata[17];
  end

  // Hold the delay register
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_delay_ticks <= DELAY_RESET;
    end else if (cfg_wr_en) begin
      bit_delay_ticks <= cfg_wr_data;
    end
  end

  // Run a tick when the result register can take it
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign step     = held_valid && out_free;

  i2cm_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (in_cmd),
    .held_valid (held_valid),
    .held_cmd   (held_cmd),
    .take       (step)
  );

  i2cm_core #(
    .DELAY_COUNTER_BITS (DELAY_COUNTER_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .cmd             (held_cmd),
    .bit_delay_ticks (bit_delay_ticks),
    .res             (res)
  );

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= step;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {3'b000, res.read_data, res.ack_bit, res.done_res,
                       res.busy_res, res.sda_drive_low, res.scl_drive_low};
    end
  end

endmodule

// ===== hw/rtl/i2cm_checker.sv =====
// Port-level checks for the I2C master bit sequencer, bound to its top level.
// Depends on i2cm_pkg and i2c_master_bit_sequencer_defines.svh.
`include "i2c_master_bit_sequencer_defines.svh"

module i2cm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic [i2cm_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready
);
  import i2cm_pkg::*;

  // A stalled result beat holds
  `I2CM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // Done and busy never show together
  `I2CM_ASSERT(a_done_idle, m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[2]), "done while busy")

  // An open output never blocks the input
  `I2CM_ASSERT(a_ready_flow, m_axis_tready |-> s_axis_tready, "input blocked with output open")

  // Reset empties the result register
  `I2CM_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_chk (.*);
